[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/gdda_pkg.sv]
package gdda_pkg;

   // Shared divider geometry
   localparam int DIV_DW = 30;
   localparam int DIV_SW = 21;
   localparam int JD_W   = 23;

   // Action codes
   localparam logic [2:0] ACT_SET   = 3'd0;
   localparam logic [2:0] ACT_ADV   = 3'd1;
   localparam logic [2:0] ACT_BACK  = 3'd2;
   localparam logic [2:0] ACT_MONTH = 3'd3;
   localparam logic [2:0] ACT_DIFF  = 3'd4;

   // Status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_DEFAULT = 2'd1;
   localparam logic [1:0] STS_RANGE   = 2'd2;

   // Default date and day number limits
   localparam logic [3:0]  DEF_MONTH = 4'd5;
   localparam logic [4:0]  DEF_DAY   = 5'd11;
   localparam logic [13:0] DEF_YEAR  = 14'd1959;
   localparam logic [13:0] YEAR_MAX  = 14'd9999;
   localparam logic [22:0] DEF_JD    = 23'd2436700;
   localparam logic signed [24:0] JD_MIN = 25'sd1721426;
   localparam logic signed [24:0] JD_MAX = 25'sd5373484;

   typedef struct packed {
      logic [3:0]         cur_month;
      logic [4:0]         cur_day;
      logic [13:0]        cur_year;
      logic [8:0]         day_of_year;
      logic [2:0]         weekday;
      logic signed [22:0] days_between;
      logic [1:0]         status;
   } gdda_result_type;

   // Days in month m of a year with the given leap flag
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[src/gdda_div.sv]
module gdda_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gdda_pkg::DIV_DW-1:0]   dividend,
   input  logic [gdda_pkg::DIV_SW-1:0]   divisor,
   output logic                          done,
   output logic [gdda_pkg::DIV_DW-1:0]   quotient,
   output logic [gdda_pkg::DIV_SW-1:0]   remainder
);
   import gdda_pkg::*;
`include "assert_macros.svh"

   // Reciprocals floor(2^32 / d) of the divisors in use
   localparam logic [63:0] RADIX     = 64'd1 << 32;
   localparam logic [31:0] RCP_7     = 32'(RADIX / 64'd7);
   localparam logic [31:0] RCP_12    = 32'(RADIX / 64'd12);
   localparam logic [31:0] RCP_80    = 32'(RADIX / 64'd80);
   localparam logic [31:0] RCP_100   = 32'(RADIX / 64'd100);
   localparam logic [31:0] RCP_2447  = 32'(RADIX / 64'd2447);
   localparam logic [31:0] RCP_146K  = 32'(RADIX / 64'd146097);
   localparam logic [31:0] RCP_1461K = 32'(RADIX / 64'd1461001);

   typedef enum logic [2:0] {
      P_EST  = 3'b001,
      P_BACK = 3'b010,
      P_FIX  = 3'b100
   } div_phase_type;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   div_phase_type     phase_ff, phase_in;
   logic [DIV_DW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] dsr_ff, dsr_in;
   logic [31:0]       rcp_ff, rcp_in;
   logic [DIV_SW:0]   rem_ff, rem_in;
   logic [31:0]       rcp_sel;
   logic [DIV_DW+31:0]       est;
   logic [DIV_DW+DIV_SW-1:0] back;

   // Look up the reciprocal of the requested divisor
   always_comb begin
      case (divisor)
         DIV_SW'(7):       rcp_sel = RCP_7;
         DIV_SW'(12):      rcp_sel = RCP_12;
         DIV_SW'(80):      rcp_sel = RCP_80;
         DIV_SW'(100):     rcp_sel = RCP_100;
         DIV_SW'(2447):    rcp_sel = RCP_2447;
         DIV_SW'(146097):  rcp_sel = RCP_146K;
         DIV_SW'(1461001): rcp_sel = RCP_1461K;
         default:          rcp_sel = '0;
      endcase
   end

   // Quotient estimate, at most one below the true quotient
   assign est  = {{32{1'b0}}, num_ff} * {{DIV_DW{1'b0}}, rcp_ff};
   // Estimate times divisor, to recover the remainder
   assign back = {{DIV_SW{1'b0}}, quo_ff} * {{DIV_DW{1'b0}}, dsr_ff};

   // Estimate, multiply back, then one compare and subtract
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      rcp_in   = rcp_ff;
      rem_in   = rem_ff;
      if (busy_ff) begin
         case (phase_ff)
            P_EST: begin
               quo_in   = est[DIV_DW+31:32];
               phase_in = P_BACK;
            end
            P_BACK: begin
               rem_in   = (DIV_SW+1)'(num_ff - back[DIV_DW-1:0]);
               phase_in = P_FIX;
            end
            default: begin
               if (rem_ff >= {1'b0, dsr_ff}) begin
                  quo_in = quo_ff + 1'b1;
                  rem_in = rem_ff - {1'b0, dsr_ff};
               end
               phase_in = P_EST;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
         endcase
      end else if (start && !done_ff) begin
         busy_in  = 1'b1;
         phase_in = P_EST;
         num_in   = dividend;
         dsr_in   = divisor;
         rcp_in   = rcp_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= P_EST;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rcp_ff <= rcp_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIV_SW-1:0];

   `CHK_IMPLY(a_done_idle, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `CHK_NEXT(a_fix_done, clock, reset, busy_ff && phase_ff == P_FIX, done_ff && !busy_ff, "divider did not finish")
   `CHK_IMPLY(a_rem_range, clock, reset, done_ff, rem_ff < {1'b0, dsr_ff}, "remainder not below divisor")

endmodule

[src/gdda_core.sv]
module gdda_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   output logic                      item_ready,
   input  logic [2:0]                in_action,
   input  logic [3:0]                in_month,
   input  logic [4:0]                in_day,
   input  logic [13:0]               in_year,
   input  logic [21:0]               in_day_count,
   output logic                      res_valid,
   input  logic                      res_ready,
   output gdda_pkg::gdda_result_type res
);
   import gdda_pkg::*;
`include "assert_macros.svh"

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_TJ_MUL   = 15'b000000000000010,
      S_TJ_CEN   = 15'b000000000000100,
      S_FJ_N     = 15'b000000000001000,
      S_FJ_I     = 15'b000000000010000,
      S_FJ_J     = 15'b000000000100000,
      S_FJ_K     = 15'b000000001000000,
      S_DISPATCH = 15'b000000010000000,
      S_CHECK    = 15'b000000100000000,
      S_ADV_LOAD = 15'b000001000000000,
      S_LEAP     = 15'b000010000000000,
      S_FIN      = 15'b000100000000000,
      S_FIN_YDAY = 15'b001000000000000,
      S_FIN_WDAY = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } gdda_state_type;

   gdda_state_type state_ff, state_in;
   gdda_state_type tj_ret_ff, tj_ret_in;
   gdda_state_type fj_ret_ff, fj_ret_in;

   logic [13:0] date_y_ff, date_y_in;
   logic [3:0]  date_m_ff, date_m_in;
   logic [4:0]  date_d_ff, date_d_in;

   logic [2:0]  act_ff, act_in;
   logic [3:0]  im_ff, im_in;
   logic [4:0]  id_ff, id_in;
   logic [13:0] iy_ff, iy_in;
   logic [21:0] cnt_ff, cnt_in;

   logic [13:0] ty_ff, ty_in;
   logic [3:0]  tm_ff, tm_in;
   logic [4:0]  td_ff, td_in;
   logic [8:0]  p_ff, p_in;
   logic [22:0] jd_ff, jd_in;
   logic [22:0] cur_ff, cur_in;
   logic [22:0] fj_ff, fj_in;
   logic [22:0] l_ff, l_in;
   logic [7:0]  n_ff, n_in;
   logic [9:0]  i_ff, i_in;
   logic [5:0]  j_ff, j_in;
   logic [13:0] fy_ff, fy_in;
   logic [3:0]  fm_ff, fm_in;
   logic [4:0]  fd_ff, fd_in;

   logic [1:0]         status_ff, status_in;
   logic signed [22:0] diff_ff, diff_in;
   logic [8:0]         doy_ff, doy_in;
   logic [2:0]         wday_ff, wday_in;

   // Shared divider
   logic              div_start, div_done;
   logic [DIV_DW-1:0] div_num, div_quo;
   logic [DIV_SW-1:0] div_den, div_rem;

   gdda_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Day number from date: month term and century term
   logic              am;
   logic [3:0]        mm;
   logic [14:0]       cen, ya;
   logic [25:0]       y1461, jd_sum;
   logic [9:0]        q3;
   // Date from day number
   logic [23:0]       l0;
   logic [25:0]       nmul, l1;
   logic              l2;
   logic [14:0]       fy_calc;
   // Dispatch and result helpers
   logic signed [24:0] nj;
   logic              rt_ok, leap;
   logic [13:0]       ny;
   logic [3:0]        nm;
   logic [4:0]        mlen;
   logic [23:0]       diff_wide;
   logic [22:0]       doy_wide;

   assign am     = (tm_ff <= 4'd2);
   assign mm     = am ? tm_ff + 4'd10 : tm_ff - 4'd2;
   assign cen    = 15'(ty_ff) + (am ? 15'd4899 : 15'd4900);
   assign ya     = 15'(ty_ff) + (am ? 15'd4799 : 15'd4800);
   assign y1461  = 26'd1461 * 26'(ya);
   assign q3     = 10'd3 * 10'(div_quo[7:0]);
   assign jd_sum = 26'(td_ff) + (y1461 >> 2) + 26'(p_ff) - 26'(q3 >> 2) - 26'd32075;

   assign l0      = 24'(fj_ff) + 24'd68569;
   assign nmul    = 26'd146097 * 26'(div_quo[7:0]);
   assign l1      = 26'(l0) - ((nmul + 26'd3) >> 2);
   assign l2      = (j_ff >= 6'd11);
   assign fy_calc = 15'd100 * 15'(n_ff - 8'd49) + 15'(i_ff) + 15'(l2);

   assign nj = (act_ff == ACT_ADV) ? $signed({2'b00, jd_ff}) + $signed({3'b000, cnt_ff})
                                   : $signed({2'b00, jd_ff}) - $signed({3'b000, cnt_ff});
   assign rt_ok = (fy_ff == iy_ff) && (fm_ff == im_ff) && (fd_ff == id_ff);
   assign ny    = (date_m_ff >= 4'd12) ? date_y_ff + 14'd1 : date_y_ff;
   assign nm    = (date_m_ff >= 4'd12) ? 4'd1 : date_m_ff + 4'd1;
   assign leap  = ((ty_ff[1:0] == 2'd0) && (div_rem[6:0] != 7'd0)) ||
                  ((div_rem[6:0] == 7'd0) && (div_quo[1:0] == 2'd0));
   assign mlen  = month_len(leap, tm_ff);
   assign diff_wide = {1'b0, (rt_ok ? jd_ff : DEF_JD)} - {1'b0, cur_ff};
   assign doy_wide  = cur_ff - jd_ff + 23'd1;

   // Pick the divider operands for the current step
   always_comb begin
      div_num = '0;
      div_den = '0;
      case (state_ff)
         S_TJ_MUL: begin
            div_num = DIV_DW'(13'd367 * 13'(mm));
            div_den = DIV_SW'(12);
         end
         S_TJ_CEN: begin
            div_num = DIV_DW'(cen);
            div_den = DIV_SW'(100);
         end
         S_FJ_N: begin
            div_num = DIV_DW'({l0, 2'b00});
            div_den = DIV_SW'(146097);
         end
         S_FJ_I: begin
            div_num = 30'd4000 * (30'(l_ff) + 30'd1);
            div_den = DIV_SW'(1461001);
         end
         S_FJ_J: begin
            div_num = 30'd80 * 30'(l_ff);
            div_den = DIV_SW'(2447);
         end
         S_FJ_K: begin
            div_num = 30'd2447 * 30'(j_ff);
            div_den = DIV_SW'(80);
         end
         S_LEAP: begin
            div_num = DIV_DW'(ty_ff);
            div_den = DIV_SW'(100);
         end
         S_FIN_WDAY: begin
            div_num = DIV_DW'(cur_ff);
            div_den = DIV_SW'(7);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   assign div_start = !div_done &&
      (state_ff == S_TJ_MUL || state_ff == S_TJ_CEN || state_ff == S_FJ_N ||
       state_ff == S_FJ_I || state_ff == S_FJ_J || state_ff == S_FJ_K ||
       state_ff == S_LEAP || state_ff == S_FIN_WDAY);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      tj_ret_in = tj_ret_ff;
      fj_ret_in = fj_ret_ff;
      date_y_in = date_y_ff;
      date_m_in = date_m_ff;
      date_d_in = date_d_ff;
      act_in    = act_ff;
      im_in     = im_ff;
      id_in     = id_ff;
      iy_in     = iy_ff;
      cnt_in    = cnt_ff;
      ty_in     = ty_ff;
      tm_in     = tm_ff;
      td_in     = td_ff;
      p_in      = p_ff;
      jd_in     = jd_ff;
      cur_in    = cur_ff;
      fj_in     = fj_ff;
      l_in      = l_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      fy_in     = fy_ff;
      fm_in     = fm_ff;
      fd_in     = fd_ff;
      status_in = status_ff;
      diff_in   = diff_ff;
      doy_in    = doy_ff;
      wday_in   = wday_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               act_in    = in_action;
               im_in     = in_month;
               id_in     = in_day;
               iy_in     = in_year;
               cnt_in    = in_day_count;
               ty_in     = date_y_ff;
               tm_in     = date_m_ff;
               td_in     = date_d_ff;
               status_in = STS_OK;
               diff_in   = '0;
               tj_ret_in = S_DISPATCH;
               state_in  = S_TJ_MUL;
            end
         end
         S_TJ_MUL: begin
            if (div_done) begin
               p_in     = div_quo[8:0];
               state_in = S_TJ_CEN;
            end
         end
         S_TJ_CEN: begin
            if (div_done) begin
               jd_in    = jd_sum[22:0];
               fj_in    = jd_sum[22:0];
               state_in = tj_ret_ff;
            end
         end
         S_FJ_N: begin
            if (div_done) begin
               n_in     = div_quo[7:0];
               l_in     = l1[22:0];
               state_in = S_FJ_I;
            end
         end
         S_FJ_I: begin
            if (div_done) begin
               i_in     = div_quo[9:0];
               l_in     = l_ff - 23'((23'd1461 * 23'(div_quo[9:0])) >> 2) + 23'd31;
               state_in = S_FJ_J;
            end
         end
         S_FJ_J: begin
            if (div_done) begin
               j_in     = div_quo[5:0];
               state_in = S_FJ_K;
            end
         end
         S_FJ_K: begin
            if (div_done) begin
               fd_in    = 5'(l_ff - div_quo[22:0]);
               fm_in    = l2 ? 4'(j_ff - 6'd10) : 4'(j_ff + 6'd2);
               fy_in    = fy_calc[13:0];
               state_in = fj_ret_ff;
            end
         end
         S_DISPATCH: begin
            cur_in   = jd_ff;
            state_in = S_FIN;
            if (act_ff == ACT_SET || act_ff == ACT_DIFF) begin
               if (iy_ff == 14'd0 || iy_ff > YEAR_MAX) begin
                  status_in = STS_RANGE;
               end else begin
                  ty_in     = iy_ff;
                  tm_in     = im_ff;
                  td_in     = id_ff;
                  tj_ret_in = S_FJ_N;
                  fj_ret_in = S_CHECK;
                  state_in  = S_TJ_MUL;
               end
            end else if (act_ff == ACT_ADV || act_ff == ACT_BACK) begin
               if (nj < JD_MIN || nj > JD_MAX) begin
                  status_in = STS_RANGE;
               end else begin
                  fj_in     = nj[22:0];
                  fj_ret_in = S_ADV_LOAD;
                  state_in  = S_FJ_N;
               end
            end else if (act_ff == ACT_MONTH) begin
               if (ny > YEAR_MAX) begin
                  status_in = STS_RANGE;
               end else begin
                  ty_in    = ny;
                  tm_in    = nm;
                  state_in = S_LEAP;
               end
            end
         end
         S_CHECK: begin
            if (act_ff == ACT_SET) begin
               if (rt_ok) begin
                  date_y_in = iy_ff;
                  date_m_in = im_ff;
                  date_d_in = id_ff;
               end else begin
                  date_y_in = DEF_YEAR;
                  date_m_in = DEF_MONTH;
                  date_d_in = DEF_DAY;
               end
            end else begin
               diff_in = $signed(diff_wide[22:0]);
            end
            status_in = rt_ok ? STS_OK : STS_DEFAULT;
            state_in  = S_FIN;
         end
         S_ADV_LOAD: begin
            date_y_in = fy_ff;
            date_m_in = fm_ff;
            date_d_in = fd_ff;
            state_in  = S_FIN;
         end
         S_LEAP: begin
            if (div_done) begin
               date_y_in = ty_ff;
               date_m_in = tm_ff;
               date_d_in = (date_d_ff < mlen) ? date_d_ff : mlen;
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            ty_in     = date_y_ff;
            tm_in     = date_m_ff;
            td_in     = date_d_ff;
            tj_ret_in = S_FIN_YDAY;
            state_in  = S_TJ_MUL;
         end
         S_FIN_YDAY: begin
            cur_in    = jd_ff;
            tm_in     = 4'd1;
            td_in     = 5'd1;
            tj_ret_in = S_FIN_WDAY;
            state_in  = S_TJ_MUL;
         end
         S_FIN_WDAY: begin
            if (div_done) begin
               doy_in   = doy_wide[8:0];
               wday_in  = div_rem[2:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tj_ret_ff <= S_DISPATCH;
         fj_ret_ff <= S_CHECK;
         date_y_ff <= DEF_YEAR;
         date_m_ff <= DEF_MONTH;
         date_d_ff <= DEF_DAY;
      end else begin
         state_ff  <= state_in;
         tj_ret_ff <= tj_ret_in;
         fj_ret_ff <= fj_ret_in;
         date_y_ff <= date_y_in;
         date_m_ff <= date_m_in;
         date_d_ff <= date_d_in;
      end
      act_ff    <= act_in;
      im_ff     <= im_in;
      id_ff     <= id_in;
      iy_ff     <= iy_in;
      cnt_ff    <= cnt_in;
      ty_ff     <= ty_in;
      tm_ff     <= tm_in;
      td_ff     <= td_in;
      p_ff      <= p_in;
      jd_ff     <= jd_in;
      cur_ff    <= cur_in;
      fj_ff     <= fj_in;
      l_ff      <= l_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      fy_ff     <= fy_in;
      fm_ff     <= fm_in;
      fd_ff     <= fd_in;
      status_ff <= status_in;
      diff_ff   <= diff_in;
      doy_ff    <= doy_in;
      wday_ff   <= wday_in;
   end

   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);

   always_comb begin
      res.cur_month    = date_m_ff;
      res.cur_day      = date_d_ff;
      res.cur_year     = date_y_ff;
      res.day_of_year  = doy_ff;
      res.weekday      = wday_ff;
      res.days_between = diff_ff;
      res.status       = status_ff;
   end

   `CHK_IMPLY(a_date_sane, clock, reset, state_ff == S_DONE, date_m_ff >= 4'd1 && date_m_ff <= 4'd12 && date_d_ff != 5'd0 && wday_ff <= 3'd6, "bad date in result")
   `CHK_IMPLY(a_diff_only, clock, reset, state_ff == S_DONE && diff_ff != 23'sd0, act_ff == ACT_DIFF, "difference set by other action")
   `CHK_IMPLY(a_div_owner, clock, reset, div_done, state_ff == S_TJ_MUL || state_ff == S_TJ_CEN || state_ff == S_FJ_N || state_ff == S_FJ_I || state_ff == S_FJ_J || state_ff == S_FJ_K || state_ff == S_LEAP || state_ff == S_FIN_WDAY, "divider result with no consumer")

endmodule

[src/gregorian_date_day_arithmetic_top.sv]
// Gregorian date unit with day arithmetic.
// Input channel req_*: one item per action (set date, advance days, go back
// days, add month, difference to another date). Result channel rsp_*: exactly
// one item per input item, carrying the date after the action, day of year,
// weekday (0 Monday), signed day difference and status.
// All divisions run on one shared divider that works by reciprocal
// multiplication with one correction step, and the sequencer waits on each
// division. An item takes 7 divisions for the current day number and the
// result fields, plus 6 for set or difference, 4 for advance or go back and
// 1 for add month. req_tready is high only while the sequencer is idle, so
// a new item is taken only once the last one has been handed on as a result.
// The result sits in an output register; the next item is accepted while it
// waits. If rsp_tready stays low the sequencer holds its finished result,
// and takes no items, until the register drains.
// Reset loads the date 1959-05-11 and empties the output register; no
// clearing pass is needed.
module gregorian_date_day_arithmetic_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], in_month[6:3], in_day[11:7], in_year[25:12], day_count[47:26]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cur_month[3:0], cur_day[8:4], cur_year[22:9], day_of_year[31:23],
   // weekday[34:32], days_between[57:35], status[59:58], zero[63:60]
   output logic [63:0] rsp_tdata
);
   import gdda_pkg::*;

   logic            res_valid, res_ready;
   gdda_result_type res;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_data_ff, rsp_data_in;

   gdda_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .in_action    (req_tdata[2:0]),
      .in_month     (req_tdata[6:3]),
      .in_day       (req_tdata[11:7]),
      .in_year      (req_tdata[25:12]),
      .in_day_count (req_tdata[47:26]),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // Load the output register when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {4'd0, res.status, res.days_between, res.weekday,
                           res.day_of_year, res.cur_year, res.cur_day, res.cur_month};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
